### rtl/psrp_pkg.sv
package psrp_pkg;

  // Field and register widths
  localparam int RANGE_W   = 16;
  localparam int ANGLE_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int COORD_W   = 9;
  localparam int BEAM_W    = 12;

  // Image geometry
  localparam int IMAGE_SIZE = 500;
  localparam int HALF_SIZE  = IMAGE_SIZE / 2;
  localparam int MAX_BEAMS  = 4096;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE   = 2'd3;

  // CORDIC datapath: x, y in Q30 with headroom, angle in 2^32 units per turn
  localparam int CORDIC_ITERS = 30;
  localparam int ITER_W       = $clog2(CORDIC_ITERS);
  localparam int XY_W         = 34;
  localparam int Z_W          = 32;
  localparam int ATAN_W       = 30;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Q16 trig value, clamped to +/-1.0
  localparam int TRIG_W     = 18;
  localparam int TRIG_MAG_W = 17;

  // Projection datapath: r*IMAGE_SIZE, times |trig|, then drop 16 frac bits
  // and the factor of two in the denominator
  localparam int SCALE_W = $clog2(IMAGE_SIZE + 1);
  localparam int R500_W  = RANGE_W + SCALE_W;
  localparam int PROD_W  = R500_W + TRIG_MAG_W;
  localparam int DROP_W  = 17;
  localparam int DVD_W   = PROD_W - DROP_W;
  localparam int QBITS   = $clog2(HALF_SIZE);
  localparam int DIV_CNT_W = $clog2(QBITS);
  localparam int PIX_W   = COORD_W + 2;

  // Arctangent of 2^-i in 2^32 units per turn
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [ITER_W-1:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Round Q30 to Q16 (floor of v + half LSB) and clamp to +/-1.0
  function automatic logic signed [TRIG_W-1:0] to_q16(input logic signed [XY_W-1:0] v);
    logic signed [XY_W-1:0] t;
    t = (v + 34'sd8192) >>> 14;
    if (t > 34'sd65536) begin
      t = 34'sd65536;
    end else if (t < -34'sd65536) begin
      t = -34'sd65536;
    end
    return t[TRIG_W-1:0];
  endfunction

endpackage

### rtl/polar_scan_to_raster_point.sv
// Channel | Direction | Handshake             | Payload
// in_     | input     | in_valid / in_ready   | range_mm[15:0], last_beam
// out_    | output    | out_valid / out_ready | plot, pixel_x[8:0], pixel_y[8:0], scan_done
// cfg_    | input     | cfg_valid / cfg_ready | index[1:0], data[15:0]
//
// In-window sample: 30 CORDIC iterations, a rounding step, then for x and then y one multiply
// and a restoring divide of 8 quotient bits each, then a load step.
// Out-of-window sample: goes from accept straight to the load step.
// in_ready returns the cycle after the load; no new item is taken while one is in flight.
// A result stalled by out_ready holds the next item in the load step until it is taken.
// rst_n is synchronous; control registers reset, beam count to 0; datapath registers do not.
module polar_scan_to_raster_point (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [psrp_pkg::RANGE_W-1:0]   in_range_mm,
  input  logic                           in_last_beam,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_plot,
  output logic [psrp_pkg::COORD_W-1:0]   out_pixel_x,
  output logic [psrp_pkg::COORD_W-1:0]   out_pixel_y,
  output logic                           out_scan_done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psrp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [psrp_pkg::CFG_W-1:0]     cfg_data
);
  import psrp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CORDIC = 3'd1;
  localparam logic [2:0] S_ROUND  = 3'd2;
  localparam logic [2:0] S_MUL    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]               state_r, state_nxt;

  // Configuration registers
  logic [ANGLE_W-1:0]       start_angle_r;
  logic [ANGLE_W-1:0]       angle_step_r;
  logic [RANGE_W-1:0]       min_range_r;
  logic [RANGE_W-1:0]       range_top_r;

  logic [BEAM_W-1:0]        beam_index_r;

  // Item context
  logic                     in_win_r;
  logic                     last_r;
  logic [1:0]               quad_r;
  logic [R500_W-1:0]        r500_r;

  // CORDIC unit
  logic signed [XY_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic [ITER_W-1:0]        iter_r;

  // Trig results
  logic signed [TRIG_W-1:0] cos_r, sin_r;

  // Multiply and divide unit
  logic                     sel_y_r;
  logic                     neg_r;
  logic [DVD_W-1:0]         rem_r;
  logic [QBITS-1:0]         quo_r;
  logic [DIV_CNT_W-1:0]     div_cnt_r;

  // Projected coordinates
  logic [COORD_W-1:0]       px_r;
  logic                     x_ok_r;
  logic [COORD_W-1:0]       py_r;
  logic                     y_ok_r;

  // Output register
  logic                     out_valid_r;
  logic                     out_plot_r;
  logic [COORD_W-1:0]       out_pixel_x_r;
  logic [COORD_W-1:0]       out_pixel_y_r;
  logic                     out_scan_done_r;

  logic                     in_fire;
  logic                     out_load;
  logic [BEAM_W:0]          beam_inc;
  logic [BEAM_W+ANGLE_W-1:0] angle_prod;
  logic [ANGLE_W-1:0]       angle;
  logic signed [XY_W-1:0]   dx, dy;
  logic signed [Z_W-1:0]    atan_v;
  logic signed [TRIG_W-1:0] cq, sq;
  logic signed [TRIG_W-1:0] trig_sel;
  logic signed [TRIG_W-1:0] trig_neg;
  logic [TRIG_MAG_W-1:0]    trig_mag;
  logic [PROD_W-1:0]        prod;
  logic [DVD_W-1:0]         dsr;
  logic                     dsr_fit;
  logic [QBITS-1:0]         quo_step;
  logic signed [PIX_W-1:0]  coord;
  logic                     coord_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  assign out_valid     = out_valid_r;
  assign out_plot      = out_plot_r;
  assign out_pixel_x   = out_pixel_x_r;
  assign out_pixel_y   = out_pixel_y_r;
  assign out_scan_done = out_scan_done_r;

  // Beam angle of the accepted item, wrapped to one turn
  assign angle_prod = (BEAM_W + ANGLE_W)'(beam_index_r) * (BEAM_W + ANGLE_W)'(angle_step_r);
  assign angle      = start_angle_r + angle_prod[ANGLE_W-1:0];
  assign beam_inc   = {1'b0, beam_index_r} + 1'b1;

  // CORDIC micro-rotation terms
  assign dx     = y_r >>> iter_r;
  assign dy     = x_r >>> iter_r;
  assign atan_v = Z_W'(atan_entry(iter_r));

  // Round and fold the quadrant back in
  always_comb begin
    logic signed [TRIG_W-1:0] cr, sr;
    cr = to_q16(x_r);
    sr = to_q16(y_r);
    case (quad_r)
      2'd0: begin
        cq = cr;
        sq = sr;
      end
      2'd1: begin
        cq = -sr;
        sq = cr;
      end
      2'd2: begin
        cq = -cr;
        sq = -sr;
      end
      default: begin
        cq = sr;
        sq = -cr;
      end
    endcase
  end

  // Shared multiplier: r*IMAGE_SIZE times |trig|
  assign trig_sel = sel_y_r ? sin_r : cos_r;
  assign trig_neg = -trig_sel;
  assign trig_mag = trig_sel[TRIG_W-1] ? trig_neg[TRIG_MAG_W-1:0]
                                       : trig_sel[TRIG_MAG_W-1:0];
  assign prod     = PROD_W'(r500_r) * PROD_W'(trig_mag);

  // Restoring divide step: one quotient bit per cycle, divisor range_top
  assign dsr      = DVD_W'(range_top_r) << div_cnt_r;
  assign dsr_fit  = (rem_r >= dsr);
  assign quo_step = quo_r | (QBITS'(dsr_fit) << div_cnt_r);

  // Signed offset from the image center and the bounds check
  always_comb begin
    logic signed [PIX_W-1:0] q;
    q = $signed(PIX_W'(quo_step));
    coord    = neg_r ? (PIX_W'(HALF_SIZE) - q) : (PIX_W'(HALF_SIZE) + q);
    coord_ok = (coord >= 0) && (coord < PIX_W'(IMAGE_SIZE));
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if ((in_range_mm > min_range_r) && (in_range_mm < range_top_r)) begin
            state_nxt = S_CORDIC;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_CORDIC: begin
        if (iter_r == ITER_W'(CORDIC_ITERS - 1)) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIV;
      S_DIV: begin
        if (div_cnt_r == '0) begin
          state_nxt = sel_y_r ? S_OUT : S_MUL;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      beam_index_r  <= '0;
      start_angle_r <= '0;
      angle_step_r  <= '0;
      min_range_r   <= '0;
      range_top_r   <= '1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // Register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_ANGLE: start_angle_r <= cfg_data;
          REG_ANGLE_STEP:  angle_step_r  <= cfg_data;
          REG_MIN_RANGE:   min_range_r   <= cfg_data;
          REG_MAX_RANGE:   range_top_r   <= cfg_data;
          default: ;
        endcase
      end

      // Advance the beam count, restart after the last beam or at MAX_BEAMS
      if (in_fire) begin
        if (in_last_beam || (beam_inc >= (BEAM_W + 1)'(MAX_BEAMS))) begin
          beam_index_r <= '0;
        end else begin
          beam_index_r <= beam_inc[BEAM_W-1:0];
        end
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          in_win_r <= (in_range_mm > min_range_r) && (in_range_mm < range_top_r);
          last_r   <= in_last_beam;
          quad_r   <= angle[ANGLE_W-1:ANGLE_W-2];
          r500_r   <= R500_W'(in_range_mm) * R500_W'(IMAGE_SIZE);
          x_r      <= CORDIC_GAIN;
          y_r      <= '0;
          z_r      <= $signed({2'b00, angle[ANGLE_W-3:0], 16'b0});
          iter_r   <= '0;
          sel_y_r  <= 1'b0;
        end
      end
      S_CORDIC: begin
        // Rotate toward zero residual angle
        if (!z_r[Z_W-1]) begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - atan_v;
        end else begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + atan_v;
        end
        iter_r <= iter_r + 1'b1;
      end
      S_ROUND: begin
        cos_r <= cq;
        sin_r <= sq;
      end
      S_MUL: begin
        neg_r     <= trig_sel[TRIG_W-1];
        rem_r     <= prod[PROD_W-1:DROP_W];
        quo_r     <= '0;
        div_cnt_r <= DIV_CNT_W'(QBITS - 1);
      end
      S_DIV: begin
        if (dsr_fit) begin
          rem_r <= rem_r - dsr;
        end
        quo_r     <= quo_step;
        div_cnt_r <= div_cnt_r - 1'b1;
        // Hold x, then switch the shared unit over to y
        if (div_cnt_r == '0) begin
          if (!sel_y_r) begin
            px_r    <= coord[COORD_W-1:0];
            x_ok_r  <= coord_ok;
            sel_y_r <= 1'b1;
          end else begin
            py_r    <= coord[COORD_W-1:0];
            y_ok_r  <= coord_ok;
          end
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_scan_done_r <= last_r;
          if (in_win_r && x_ok_r && y_ok_r) begin
            out_plot_r    <= 1'b1;
            out_pixel_x_r <= px_r;
            out_pixel_y_r <= py_r;
          end else begin
            out_plot_r    <= 1'b0;
            out_pixel_x_r <= '0;
            out_pixel_y_r <= '0;
          end
        end
      end
      default: ;
    endcase
  end

  // Partial remainder stays below the divisor scaled to the pending bits
  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |->
      ((DVD_W + 1)'(rem_r) <
       ((DVD_W + 1)'(range_top_r) << ({1'b0, div_cnt_r} + (DIV_CNT_W + 1)'(1)))))
    else $error("divide remainder out of bound");

  // A plotted point lands on the image
  a_plot_in_image: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_plot_r) |->
      ((out_pixel_x_r < COORD_W'(IMAGE_SIZE)) && (out_pixel_y_r < COORD_W'(IMAGE_SIZE))))
    else $error("plotted point outside image");

  // An accepted item keeps the block busy until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("item accepted while busy");

  // The CORDIC counter never runs past its last iteration
  a_cordic_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CORDIC) |-> (iter_r < ITER_W'(CORDIC_ITERS)))
    else $error("CORDIC iteration count overrun");

  // A result loads only from the output step and never over an untaken one
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_scan_done_r)))
    else $error("pending result overwritten");

endmodule
